// ===== sv/shs_pkg.sv =====
// Package: shared types, constants and helper functions for the scrambled Hammersley sampler.
package shs_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 6;
    localparam int ROT_W      = 24;

    localparam logic [COORD_W-1:0] PIXEL_MASK =
        COORD_W'((64'd1 << PIXEL_BITS) - 64'd1);

    localparam logic [31:0] HASH_MUL_A = 32'h7feb_352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846c_a68b;
    localparam logic [31:0] MIX_X_A    = 32'd1973;
    localparam logic [31:0] MIX_Y_A    = 32'd9277;
    localparam logic [31:0] SEED_A     = 32'h68bc_21eb;
    localparam logic [31:0] MIX_X_B    = 32'd92821;
    localparam logic [31:0] MIX_Y_B    = 32'd68917;
    localparam logic [31:0] SEED_B     = 32'h02e5_be93;
    localparam logic [31:0] HALF_STEP  = 32'h0200_0000;

    typedef struct packed {
        logic [31:0]        frame_index;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_in;

    typedef struct packed {
        logic [31:0] sample_u;
        logic [31:0] sample_v;
    } t_out;

    // Pipeline stage contents between modules
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [31:0]      hx;
        logic [31:0]      hy;
    } t_stage;

    function automatic logic [31:0] xs16(input logic [31:0] h);
        return h ^ (h >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] h);
        return h ^ (h >> 15);
    endfunction

    function automatic logic [IDX_W-1:0] rev_idx(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        for (int i = 0; i < IDX_W; i++) begin
            r[i] = x[IDX_W-1-i];
        end
        return r;
    endfunction

endpackage

// ===== sv/scrambled_hammersley_sampler_unit.sv =====
// Top level: four-stage pipelined scrambled Hammersley 2D sample generator.
//
// Usage:
//   Input channel: drive start high with i_item (frame_index, pixel_x, pixel_y);
//   the transaction is taken at the clock edge where start is high and busy
//   is low. A new transaction may be issued every cycle.
//   Output channel: each transaction yields exactly one result on o_result,
//   marked by o_valid for a single cycle. The receiver has no back-pressure
//   and must take the result in that cycle.
// Pipeline: an accepted transaction passes through the mix, hash round A,
//   hash round B and finish/assemble registers before o_valid is raised.
// Throughput: one transaction per cycle while busy is low, set by the fully
//   pipelined 32x32 constant multipliers, one per hash lane per hash round.
// Reset: synchronous, active low. All stage valid bits clear, in-flight
//   transactions are dropped, and busy is high during reset and in the
//   cycle after it is released.
// Stall: not applicable, the receiver cannot stall; results stream out in
//   order of acceptance.
module scrambled_hammersley_sampler_unit import shs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    logic   r_busy;
    logic   w_accept;
    t_stage w_s1;
    t_stage w_s3;

    // busy is held during reset and guards the cycle right after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    shs_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .o_stage (w_s1)
    );

    shs_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_s1),
        .o_stage (w_s3)
    );

    shs_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_s3),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // every accepted transaction produces a result
    a_accept_to_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_valid
    ) else $error("accepted transaction did not produce a result");

    // no result without a matching acceptance
    a_result_has_source: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 4)
    ) else $error("result strobe without accepted transaction");

    // pipeline is empty while busy after reset
    a_busy_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!o_valid && !w_s1.valid && !w_s3.valid)
    ) else $error("pipeline not empty after reset");

endmodule

// ===== sv/shs_mix.sv =====
// Stage 1: seeded linear mixes of the pixel coordinates and index capture.
module shs_mix import shs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_in    i_item,
    output t_stage o_stage
);

    logic [31:0] w_px;
    logic [31:0] w_py;
    t_stage      n_stage;
    t_stage      r_stage;

    assign w_px = 32'(i_item.pixel_x & PIXEL_MASK);
    assign w_py = 32'(i_item.pixel_y & PIXEL_MASK);

    always_comb begin
        n_stage.valid = i_valid;
        n_stage.idx   = i_item.frame_index[IDX_W-1:0];
        n_stage.hx    = w_px * MIX_X_A + w_py * MIX_Y_A + SEED_A;
        n_stage.hy    = w_px * MIX_X_B + w_py * MIX_Y_B + SEED_B;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== sv/shs_hash.sv =====
// Stages 2 and 3: the two multiply rounds of both coordinate hashes.
module shs_hash import shs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage n_s2;
    t_stage r_s2;
    t_stage n_s3;
    t_stage r_s3;

    // round A: xorshift 16, multiply
    always_comb begin
        n_s2    = i_stage;
        n_s2.hx = xs16(i_stage.hx) * HASH_MUL_A;
        n_s2.hy = xs16(i_stage.hy) * HASH_MUL_A;
    end

    // round B: xorshift 15, multiply
    always_comb begin
        n_s3    = r_s2;
        n_s3.hx = xs15(r_s2.hx) * HASH_MUL_B;
        n_s3.hy = xs15(r_s2.hy) * HASH_MUL_B;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_stage = r_s3;

endmodule

// ===== sv/shs_finish.sv =====
// Stage 4: final xorshift, index scrambling and sample assembly.
module shs_finish import shs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_out   o_result
);

    logic [31:0]      w_hx;
    logic [31:0]      w_hy;
    logic [IDX_W-1:0] w_ord;
    logic [IDX_W-1:0] w_scr;
    t_out             n_result;
    t_out             r_result;
    logic             r_valid;

    assign w_hx = xs16(i_stage.hx);
    assign w_hy = xs16(i_stage.hy);

    // top index bit flipped by parity of the low five
    assign w_ord = {i_stage.idx[IDX_W-1] ^ (^i_stage.idx[IDX_W-2:0]),
                    i_stage.idx[IDX_W-2:0]};
    assign w_scr = w_ord ^ w_hx[IDX_W-1:0];

    always_comb begin
        n_result.sample_u = {w_hx[ROT_W-1:0], 8'd0} + {w_scr, 26'd0} + HALF_STEP;
        n_result.sample_v = {w_hy[ROT_W-1:0], 8'd0} + {rev_idx(w_scr), 26'd0};
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the scrambled Hammersley sampler unit.
`timescale 1ns / 1ps

module testbench;
    import shs_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESULT_LATENCY = 4;     // accepting edge to result edge
    localparam int STALL_LIMIT    = 1000;  // cycles with no transaction at all
    localparam int MAX_REPORTS    = 10;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_valid;
    t_out o_result;

    // Samples predicted for accepted transactions, oldest first
    t_out sample_expect_q[$];

    int n_sent;
    int n_checked;
    int n_errors;
    int idle_cycles;

    scrambled_hammersley_sampler_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // xor-shift-multiply avalanche used for both rotation lanes
    function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * HASH_MUL_A;
        t = t ^ (t >> 15);
        t = t * HASH_MUL_B;
        t = t ^ (t >> 16);
        return t;
    endfunction

    function automatic t_out predict_sample(input t_in item);
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] hx;
        logic [31:0] hy;
        logic [31:0] rev;
        logic [5:0]  idx;
        logic [5:0]  ord;
        logic [5:0]  scr;
        logic        par;
        t_out        s;
        px  = 32'(item.pixel_x & PIXEL_MASK);
        py  = 32'(item.pixel_y & PIXEL_MASK);
        idx = item.frame_index[5:0];   // frame modulo 64
        hx  = avalanche_hash(px * MIX_X_A + py * MIX_Y_A + SEED_A);
        hy  = avalanche_hash(px * MIX_X_B + py * MIX_Y_B + SEED_B);
        // bit five flipped by the parity of the low five bits, then scrambled
        par = ^idx[4:0];
        ord = {idx[5] ^ par, idx[4:0]};
        scr = ord ^ hx[5:0];
        // 32-bit reversal of a 6-bit value lands in the top six bits
        rev = '0;
        for (int i = 0; i < 6; i++) begin
            rev[31-i] = scr[i];
        end
        s.sample_u = {hx[23:0], 8'h00} + {scr, 26'h0} + HALF_STEP;
        s.sample_v = {hy[23:0], 8'h00} + rev;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so every o_valid cycle
    // is a transaction and must match the oldest prediction.
    // ------------------------------------------------------------------

    task automatic note_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: expected %08h, got %08h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_out want;
        if (i_rst_n && o_valid) begin
            if (sample_expect_q.size() == 0) begin
                note_error("unexpected result (sample_u)", '0, o_result.sample_u);
            end else begin
                want = sample_expect_q.pop_front();
                n_checked++;
                if (o_result.sample_u !== want.sample_u) begin
                    note_error("sample_u", want.sample_u, o_result.sample_u);
                end
                if (o_result.sample_v !== want.sample_v) begin
                    note_error("sample_v", want.sample_v, o_result.sample_v);
                end
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Holds start high until the block takes the item; start is left high
    // so a following item goes out back to back.
    task automatic send_item(input t_in item);
        i_item <= item;
        start  <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        sample_expect_q.push_back(predict_sample(item));
        n_sent++;
    endtask

    // Random sender gap: mostly none or short, now and then long
    task automatic sender_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            len = 0;
        end else if (pick < 90) begin
            len = $urandom_range(1, 3);
        end else begin
            len = $urandom_range(10, 40);
        end
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (sample_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_in random_item();
        t_in item;
        item.frame_index = $urandom();
        item.pixel_x     = 16'($urandom_range(0, 16'hffff));
        item.pixel_y     = 16'($urandom_range(0, 16'hffff));
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, index wrap at 64 and large frame numbers
    task automatic test_directed_corners();
        logic [31:0] frames[10];
        logic [15:0] coords[4];
        t_in         item;
        frames = '{32'd0, 32'd1, 32'd31, 32'd32, 32'd63, 32'd64,
                   32'd65, 32'h8000_0000, 32'hffff_ffc0, 32'hffff_ffff};
        coords = '{16'h0000, 16'hffff, 16'h8000, 16'h0001};
        foreach (frames[i]) begin
            item.frame_index = frames[i];
            item.pixel_x     = coords[i % 4];
            item.pixel_y     = coords[(i / 4 + i) % 4];
            send_item(item);
        end
        // coordinate corner pairs with an even index sum, which also exercises mix overflow
        foreach (coords[i]) begin
            foreach (coords[j]) begin
                if ((i + j) % 2 == 0) begin
                    item.frame_index = $urandom();
                    item.pixel_x     = coords[i];
                    item.pixel_y     = coords[j];
                    send_item(item);
                end
            end
        end
        sender_gap();
    endtask

    // All 64 index values, so the parity flip of bit five is hit both ways
    task automatic test_index_sweep();
        t_in item;
        for (int k = 0; k < 64; k++) begin
            item = random_item();
            item.frame_index[5:0] = 6'(k);
            send_item(item);
            sender_gap();
        end
    endtask

    // Full-rate stretch with no idling on the sender side
    task automatic test_back_to_back();
        repeat (100) send_item(random_item());
        sender_gap();
    endtask

    // Sender holds off until the pipeline has emptied, then resumes
    task automatic test_drain_pause();
        repeat (20) begin
            send_item(random_item());
            sender_gap();
        end
        start <= 1'b0;
        wait_drained();
        repeat (20) begin
            send_item(random_item());
            sender_gap();
        end
    endtask

    task automatic test_random_stream();
        repeat (200) begin
            send_item(random_item());
            sender_gap();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_index_sweep();
        test_back_to_back();
        test_drain_pause();
        test_random_stream();

        // last item may still hold start high; drop it before draining
        start <= 1'b0;
        wait_drained();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);

        if (sample_expect_q.size() != 0) begin
            n_errors += sample_expect_q.size();
            $display("%0d expected samples never arrived", sample_expect_q.size());
        end
        $display("Covered %0d sample requests (corners, all 64 indices, full-rate and gapped",
                 n_sent);
        $display("streams, one drain pause); %0d samples checked, %0d errors",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/shs_pkg.sv
sv/shs_mix.sv
sv/shs_hash.sv
sv/shs_finish.sv
sv/scrambled_hammersley_sampler_unit.sv
bench/testbench.sv
